### src/wwra_pkg.sv
// Shared types and constants for the wind and rain accumulator.
`timescale 1ns / 1ps
`default_nettype none
package wwra_pkg;
    localparam int RING_SLOTS   = 120;
    localparam int GUST_MINUTES = 10;
    localparam int RAIN_MINUTES = 60;
    localparam int RING_W = $clog2(RING_SLOTS);
    localparam int GUST_W = $clog2(GUST_MINUTES);
    localparam int RAIN_W = $clog2(RAIN_MINUTES);

    localparam logic [1:0] OP_WIND = 2'd0;
    localparam logic [1:0] OP_RAIN = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_GAIN     = 2'd1;
    localparam logic [1:0] REG_RAIN     = 2'd2;

    localparam logic [4:0] NO_SECTOR = 5'd16;
    localparam logic [5:0] SECONDS_LAST = 6'd59;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] timestamp_us;
        logic [11:0] adc_sample;
        logic [6:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic        click_accepted;
        logic [23:0] wind_speed;
        logic [4:0]  wind_sector;
        logic [23:0] gust_speed;
        logic [4:0]  gust_sector;
        logic [23:0] day_gust_speed;
        logic [4:0]  day_gust_sector;
        logic [31:0] rain_today;
        logic [31:0] rain_since_last;
        logic [23:0] rain_slot;
    } out_item_t;

    typedef struct packed {
        logic [23:0] speed;
        logic [4:0]  sector;
    } wind_entry_t;

    // Classified command from front to back
    typedef struct packed {
        logic [1:0]  operation;
        logic        accepted;
        logic [23:0] speed;
        logic [4:0]  sector;
        logic [6:0]  read_index;
    } cmd_t;

    function automatic logic [4:0] vane_sector(input logic [11:0] adc);
        logic [11:0] bound [16];
        logic [4:0]  code  [16];
        logic [4:0]  res;
        bound = '{12'h12B, 12'h161, 12'h1B7, 12'h26E, 12'h35A, 12'h427, 12'h56A,
                  12'h6C6, 12'h849, 12'h99A, 12'hA69, 12'hBA0, 12'hC99, 12'hD64,
                  12'hE50, 12'hF61};
        code = '{5'd5, 5'd3, 5'd4, 5'd7, 5'd6, 5'd9, 5'd8, 5'd1, 5'd2, 5'd11,
                 5'd10, 5'd15, 5'd0, 5'd13, 5'd14, 5'd12};
        res = NO_SECTOR;
        for (int i = 15; i >= 0; i--)
        begin
            if (adc < bound[i])
            begin
                res = code[i];
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [15:0] b);
        logic [24:0] s;
        s = {1'b0, a} + {9'd0, b};
        return s[24] ? 24'hFF_FFFF : s[23:0];
    endfunction
endpackage
`default_nettype wire

### src/wwra_stream_if.sv
// Valid/ready channel interface for input items and results.
`timescale 1ns / 1ps
`default_nettype none
interface wwra_in_if;
    import wwra_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wwra_out_if;
    import wwra_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/weather_wind_rain_accumulator.sv
// Top level of the wind and rain accumulator.
// A result is registered after its input transfer: the command passes the queue, then the result register.
// Throughput: one item per cycle while the queue is not full; the front classifies in the transfer cycle.
// A two-entry command queue lets the front run while the result waits; input stalls when full.
// Reset (rst_n, async low) clears counters, registers and the valid bits of the ring
// and rain stores, so unwritten slots read as zero.
`timescale 1ns / 1ps
`default_nettype none
module weather_wind_rain_accumulator
    import wwra_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    wwra_in_if.sink          in_ch,
    wwra_out_if.source       out_ch
);
    logic [31:0] debounce_reg;
    logic [15:0] gain_reg, rain_reg;
    cmd_t        front_cmd, queue_cmd;
    logic        take, full, not_empty, pop;

    assign in_ch.ready = !full;
    assign take = in_ch.valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= 32'd10000;
            gain_reg <= 16'd614;
            rain_reg <= 16'd279;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data;
                REG_GAIN:     gain_reg <= cfg_data[15:0];
                REG_RAIN:     rain_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    wwra_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .item(in_ch.data),
        .debounce_us(debounce_reg), .wind_gain(gain_reg), .cmd(front_cmd)
    );

    wwra_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(take), .push_data(front_cmd), .full(full),
        .pop(pop), .not_empty(not_empty), .pop_data(queue_cmd)
    );

    wwra_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(not_empty), .cmd(queue_cmd), .cmd_pop(pop),
        .rain_per_click(rain_reg), .res(out_ch)
    );
endmodule
`default_nettype wire

### src/wwra_front.sv
// Front end: debounces clicks, counts wind clicks and forms tick readings.
`timescale 1ns / 1ps
`default_nettype none
module wwra_front
    import wwra_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        take,
    input  wire in_item_t    item,
    input  wire logic [31:0] debounce_us,
    input  wire logic [15:0] wind_gain,
    output cmd_t             cmd
);
    logic [7:0]  click_count_reg, click_count_next;
    logic [63:0] last_wind_reg, last_wind_next;
    logic [63:0] last_rain_reg, last_rain_next;
    logic        pass;
    logic [63:0] last_sel;
    logic [23:0] product;

    assign last_sel = (item.operation == OP_WIND) ? last_wind_reg : last_rain_reg;
    assign pass = (item.timestamp_us - last_sel) > {32'd0, debounce_us};
    assign product = 24'({8'd0, click_count_reg} * {8'd0, wind_gain});

    always_comb
    begin
        click_count_next = click_count_reg;
        last_wind_next = last_wind_reg;
        last_rain_next = last_rain_reg;
        cmd.operation = item.operation;
        cmd.accepted = 1'b0;
        cmd.speed = product;
        cmd.sector = vane_sector(item.adc_sample);
        cmd.read_index = item.read_index;
        if (take)
        begin
            unique case (item.operation)
                OP_WIND:
                begin
                    if (pass)
                    begin
                        cmd.accepted = 1'b1;
                        last_wind_next = item.timestamp_us;
                        if (click_count_reg != 8'hFF)
                        begin
                            click_count_next = click_count_reg + 8'd1;
                        end
                    end
                end
                OP_RAIN:
                begin
                    if (pass)
                    begin
                        cmd.accepted = 1'b1;
                        last_rain_next = item.timestamp_us;
                    end
                end
                OP_TICK: click_count_next = 8'd0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_count_reg <= '0;
            last_wind_reg <= '0;
            last_rain_reg <= '0;
        end
        else
        begin
            click_count_reg <= click_count_next;
            last_wind_reg <= last_wind_next;
            last_rain_reg <= last_rain_next;
        end
    end
endmodule
`default_nettype wire

### src/wwra_queue.sv
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module wwra_queue
    import wwra_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      pop_data
);
    cmd_t       slot_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg;

    assign full = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_data = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### src/wwra_back.sv
// Back end: ring, gust, rain stores and result register.
`timescale 1ns / 1ps
`default_nettype none
module wwra_back
    import wwra_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    input  wire cmd_t        cmd,
    output logic             cmd_pop,
    input  wire logic [15:0] rain_per_click,
    wwra_out_if.source       res
);
    wind_entry_t ring_reg [RING_SLOTS];
    logic [RING_SLOTS-1:0] ring_vld_reg;
    wind_entry_t gust_reg [GUST_MINUTES];
    logic [23:0] rain_reg [RAIN_MINUTES];
    logic [RAIN_MINUTES-1:0] rain_vld_reg;
    logic [23:0] rain_cur_reg, rain_cur_next;
    logic [RING_W-1:0] ring_pos_reg, ring_pos_next;
    logic [5:0]  sec_reg;
    logic [RAIN_W-1:0] min_pos_reg, min_pos_next;
    logic [GUST_W-1:0] gust_pos_reg, gust_pos_next;
    wind_entry_t day_reg, cur_reg, cur_next;
    logic [31:0] total_reg, recent_reg;
    logic        out_vld_reg;
    out_item_t   out_reg;
    wind_entry_t ring_q_reg;
    logic [23:0] rain_q_reg;
    logic        ring_use_reg, rain_use_reg;
    logic        wrap;
    wind_entry_t gust_cur, gust_after, gust_rd;
    logic [31:0] total_next, recent_next;
    wind_entry_t day_next;
    logic        is_tick, is_rain, is_read, ring_hit, rain_hit, rain_here;
    logic [RING_W-1:0] ring_addr;
    logic [RAIN_W-1:0] rain_addr;
    out_item_t   res_data;

    assign cmd_pop = cmd_valid && (!out_vld_reg || res.ready);
    assign res.valid = out_vld_reg;
    assign res.data = res_data;

    always_comb
    begin
        res_data = out_reg;
        if (ring_use_reg)
        begin
            res_data.wind_speed = ring_q_reg.speed;
            res_data.wind_sector = ring_q_reg.sector;
        end
        if (rain_use_reg)
        begin
            res_data.rain_slot = rain_q_reg;
        end
    end

    assign is_tick = cmd.operation == OP_TICK;
    assign is_rain = (cmd.operation == OP_RAIN) && cmd.accepted;
    assign is_read = cmd.operation == OP_READ;
    assign wrap = is_tick && (sec_reg == SECONDS_LAST);
    assign ring_pos_next = (32'(ring_pos_reg) + 1 >= RING_SLOTS) ? '0 : ring_pos_reg + 1'b1;
    assign min_pos_next = (32'(min_pos_reg) + 1 >= RAIN_MINUTES) ? '0 : min_pos_reg + 1'b1;
    assign gust_pos_next = (32'(gust_pos_reg) + 1 >= GUST_MINUTES) ? '0 : gust_pos_reg + 1'b1;
    assign cur_next = is_tick ? wind_entry_t'{speed: cmd.speed, sector: cmd.sector} : cur_reg;
    assign gust_cur = gust_reg[gust_pos_reg];
    assign gust_after = (is_tick && cmd.speed > gust_cur.speed) ? cur_next : gust_cur;
    assign day_next = (is_tick && cmd.speed > day_reg.speed) ? cur_next : day_reg;
    assign rain_cur_next = is_rain ? sat_add24(rain_cur_reg, rain_per_click) : rain_cur_reg;
    assign total_next = is_rain ? sat_add32(total_reg, rain_per_click) : total_reg;
    assign recent_next = is_rain ? sat_add32(recent_reg, rain_per_click) : recent_reg;
    assign ring_addr = cmd.read_index[RING_W-1:0];
    assign rain_addr = cmd.read_index[RAIN_W-1:0];
    assign ring_hit = 32'(cmd.read_index) < RING_SLOTS;
    assign rain_hit = 32'(cmd.read_index) < RAIN_MINUTES;
    assign rain_here = rain_hit && (rain_addr == min_pos_reg);
    assign gust_rd = (32'(cmd.read_index) < GUST_MINUTES)
        ? gust_reg[cmd.read_index[GUST_W-1:0]] : '0;

    always_ff @(posedge clk)
    begin
        if (cmd_pop && is_tick)
        begin
            ring_reg[ring_pos_next] <= cur_next;
        end
        if (cmd_pop && is_read && ring_hit)
        begin
            ring_q_reg <= ring_reg[ring_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && wrap)
        begin
            rain_reg[min_pos_reg] <= rain_cur_reg;
        end
        if (cmd_pop && is_read && rain_hit)
        begin
            rain_q_reg <= rain_reg[rain_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg <= '0;
            rain_vld_reg <= '0;
            for (int i = 0; i < GUST_MINUTES; i++)
            begin
                gust_reg[i] <= '0;
            end
            rain_cur_reg <= '0;
            ring_pos_reg <= '0;
            sec_reg <= '0;
            min_pos_reg <= '0;
            gust_pos_reg <= '0;
            day_reg <= '0;
            cur_reg <= '0;
            total_reg <= '0;
            recent_reg <= '0;
            out_vld_reg <= 1'b0;
            out_reg <= '0;
            ring_use_reg <= 1'b0;
            rain_use_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cmd_pop)
            begin
                cur_reg <= cur_next;
                day_reg <= day_next;
                total_reg <= total_next;
                recent_reg <= recent_next;
                gust_reg[gust_pos_reg] <= gust_after;
                rain_cur_reg <= wrap ? 24'd0 : rain_cur_next;
                ring_use_reg <= is_read && ring_hit && ring_vld_reg[ring_addr];
                rain_use_reg <= is_read && rain_hit && !rain_here && rain_vld_reg[rain_addr];
                out_reg.click_accepted <= cmd.accepted;
                out_reg.day_gust_speed <= day_next.speed;
                out_reg.day_gust_sector <= day_next.sector;
                out_reg.rain_today <= total_next;
                out_reg.rain_since_last <= recent_next;
                if (is_read)
                begin
                    out_reg.wind_speed <= 24'd0;
                    out_reg.wind_sector <= 5'd0;
                    out_reg.gust_speed <= gust_rd.speed;
                    out_reg.gust_sector <= gust_rd.sector;
                    out_reg.rain_slot <= rain_here ? rain_cur_reg : 24'd0;
                end
                else
                begin
                    out_reg.wind_speed <= cur_next.speed;
                    out_reg.wind_sector <= cur_next.sector;
                    out_reg.gust_speed <= wrap ? 24'd0 : gust_after.speed;
                    out_reg.gust_sector <= wrap ? 5'd0 : gust_after.sector;
                    out_reg.rain_slot <= wrap ? 24'd0 : rain_cur_next;
                end
                if (is_tick)
                begin
                    ring_pos_reg <= ring_pos_next;
                    ring_vld_reg[ring_pos_next] <= 1'b1;
                    sec_reg <= wrap ? 6'd0 : sec_reg + 6'd1;
                    if (wrap)
                    begin
                        min_pos_reg <= min_pos_next;
                        gust_pos_reg <= gust_pos_next;
                        rain_vld_reg[min_pos_reg] <= 1'b1;
                        gust_reg[gust_pos_next] <= '0;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

### src/wwra_checker.sv
// Port-level checker for the wind and rain accumulator.
`timescale 1ns / 1ps
`default_nettype none
module wwra_checker
    import wwra_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire in_item_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);
    logic unused_in;
    assign unused_in = in_valid ^ (^in_data);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_sector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.wind_sector <= NO_SECTOR && out_data.day_gust_sector <= NO_SECTOR)
        else $error("sector out of range");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");
    a_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid |-> out_data.rain_today >= $past(out_data.rain_today))
        else $error("rain total decreased");
endmodule

bind weather_wind_rain_accumulator wwra_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire
